FILE: hw/rtl/ppcc_pkg.sv
`default_nettype none
// ============================================================================
// ppcc_pkg
// Shared constants, functions and tables for the predicted pose coverage counter.
// ============================================================================
package ppcc_pkg;

    localparam int DEF_COUNT_WIDTH  = 16;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int MAX_STEPS        = 30;

    // Angle constants in Q16.16 and the CORDIC start gain in Q2.30.
    localparam logic signed [33:0] TWO_PI_Q16  = 34'sd411775;
    localparam logic signed [33:0] PI_Q16      = 34'sd205887;
    localparam logic signed [33:0] HALF_PI_Q16 = 34'sd102944;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic [30:0]        RADIUS_RST  = 31'd65536;

    // Heading reduction: the heading is biased by 2^31 to make it unsigned,
    // divided by 2*pi through a reciprocal scaled by 2^50, and the bias
    // (2^31 mod 2*pi) is taken off the remainder again.
    localparam logic signed [32:0] MOD_RECIP = 33'((65'd1 << 50) / 65'(TWO_PI_Q16));
    localparam logic signed [33:0] HEAD_BIAS = 34'((65'd1 << 31) % 65'(TWO_PI_Q16));

    localparam logic ACT_POSE  = 1'b0;
    localparam logic ACT_POINT = 1'b1;

    // Arctangent table in Q2.30, one entry per CORDIC step.
    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] r;
        unique case (idx)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            default: r = (idx < 5'd30) ? (34'sd1 <<< (30 - idx)) : 34'sd0;
        endcase
        return r;
    endfunction

    // Saturate a signed 66-bit value to 32-bit signed.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage : ppcc_pkg
`default_nettype wire

FILE: hw/rtl/ppcc_cordic.sv
`default_nettype none
// ============================================================================
// ppcc_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// ============================================================================
module ppcc_cordic #(
    parameter int CORDIC_STEPS = ppcc_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [33:0]        angle,   // folded angle, Q16.16
    input  wire logic                      negate,
    output logic                           done,
    output logic signed [31:0]             cos_q16,
    output logic signed [31:0]             sin_q16
);
    import ppcc_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    logic               busy_reg, busy_next;
    logic [4:0]         idx_reg, idx_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic               neg_reg, neg_next;
    logic signed [33:0] xs, ys;
    logic signed [33:0] cx, cy;

    // Shift-add step; >>> floors toward minus infinity.
    always_comb
    begin
        xs = x_reg >>> idx_reg;
        ys = y_reg >>> idx_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            x_next    = GAIN_Q30;
            y_next    = '0;
            z_next    = angle <<< 14;
            neg_next  = negate;
        end
        else if (busy_reg)
        begin
            if (idx_reg == 5'(STEPS))
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
            else
            begin
                if (!z_reg[33])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_q30(idx_reg);
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_q30(idx_reg);
                end
                idx_next = idx_reg + 5'd1;
            end
        end
    end

    assign cx = x_reg >>> 14;
    assign cy = y_reg >>> 14;
    assign cos_q16 = neg_reg ? -cx[31:0] : cx[31:0];
    assign sin_q16 = neg_reg ? -cy[31:0] : cy[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    // The step index never runs past the step count.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 5'(STEPS)) else $error("cordic index out of range");
    // Done only comes out of a busy cycle.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg) else $error("cordic done while idle");
    // Done ends the run.
    a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !start) |=> !busy_reg) else $error("cordic still busy");

endmodule : ppcc_cordic
`default_nettype wire

FILE: hw/rtl/predicted_pose_coverage_count.sv
`default_nettype none
// ============================================================================
// predicted_pose_coverage_count
// Counts frontier points within a radius of a CORDIC-predicted robot pose.
// ============================================================================
//  channel  | dir | handshake       | payload
//  s_axis   | in  | tvalid/tready   | tdata pos/heading/vel/dt, tuser action, tlast
//  m_axis   | out | tvalid/tready   | tdata covered_count
//  radius   | in  | radius_we       | radius_wdata, 31 bits
//
// A point item runs on one shared 33x33 multiplier and accumulator (three
// squares, then radius squared with the compare). A pose item reduces the
// heading with two multiplies and two wrap states, starts the CORDIC in
// one state and waits for it to finish, then does four multiplies and one
// spare state.
// Reset is asynchronous, active low; no clearing pass.
// A pending result stalls only the next item that must deliver a result.
module predicted_pose_coverage_count #(
    parameter int COUNT_WIDTH  = ppcc_pkg::DEF_COUNT_WIDTH,
    parameter int CORDIC_STEPS = ppcc_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], heading[127:96],
    // lin_vel[159:128], time_step[190:160], zero fill [191]
    input  wire logic [191:0] s_axis_tdata,
    input  wire logic         s_axis_tuser,   // action
    input  wire logic         s_axis_tlast,   // last
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // covered_count
    input  wire logic         radius_we,
    input  wire logic [30:0]  radius_wdata
);
    import ppcc_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_MOD = 4'd1, ST_CORD = 4'd2,
        ST_M1 = 4'd3, ST_M2 = 4'd4, ST_M3 = 4'd5, ST_M4 = 4'd6,
        ST_SQ = 4'd7, ST_CMP = 4'd8, ST_FOLD = 4'd9, ST_M5 = 4'd10,
        ST_REM = 4'd11, ST_WRAP = 4'd12, ST_NORM = 4'd13;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [3:0]               st_reg, st_next;
    logic [30:0]              radius_reg;
    logic signed [31:0]       pred_x_reg, pred_y_reg, pred_z_reg;
    logic [COUNT_WIDTH-1:0]   hit_reg;
    logic                     last_reg;
    logic signed [31:0]       px_reg, py_reg, vel_reg;
    logic [30:0]              dt_reg;
    logic signed [33:0]       ang_reg;
    logic signed [31:0]       q_reg;
    logic [1:0]               ax_reg;
    logic [32:0]              d_reg [3];
    logic                     far_reg;
    logic [66:0]              acc_reg;
    logic                     ovf_valid_reg;
    logic [15:0]              out_reg;
    logic                     cstart;
    logic                     cdone;
    logic signed [31:0]       cos_w, sin_w;
    logic                     acc_in;
    logic signed [65:0]       prod;
    logic signed [32:0]       ma, mb;
    logic signed [65:0]       a_w;
    logic                     hit_in;
    logic [COUNT_WIDTH-1:0]   hit_w;
    logic [15:0]              res_w;

    function automatic logic [32:0] abs34(input logic signed [33:0] v);
        return v[33] ? 33'(-v) : v[32:0];
    endfunction

    assign acc_in = s_axis_tvalid && s_axis_tready;
    // A last item needs the output slot free.
    assign s_axis_tready = (st_reg == ST_IDLE) && !(s_axis_tlast && ovf_valid_reg);
    assign m_axis_tvalid = ovf_valid_reg;
    assign m_axis_tdata  = out_reg;

    // Sequencer.
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (acc_in) st_next = (s_axis_tuser == ACT_POINT) ? ST_SQ : ST_MOD;
            ST_MOD:  st_next = ST_REM;
            ST_REM:  st_next = ST_WRAP;
            ST_WRAP: st_next = ST_NORM;
            ST_NORM: st_next = ST_FOLD;
            ST_FOLD: st_next = ST_CORD;
            ST_CORD: if (cdone) st_next = ST_M1;
            ST_M1:   st_next = ST_M2;
            ST_M2:   st_next = ST_M3;
            ST_M3:   st_next = ST_M4;
            ST_M4:   st_next = ST_M5;
            ST_M5:   st_next = ST_IDLE;
            ST_SQ:   if (ax_reg == 2'd2) st_next = ST_CMP;
            ST_CMP:  st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    assign cstart = (st_reg == ST_FOLD);

    // Shared multiplier operands.
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (st_reg)
            ST_MOD:
            begin
                ma = ang_reg[32:0];
                mb = MOD_RECIP;
            end
            ST_REM:
            begin
                ma = 33'(q_reg);
                mb = 33'(TWO_PI_Q16);
            end
            ST_M1, ST_M3:
            begin
                ma = 33'(vel_reg);
                mb = (st_reg == ST_M1) ? 33'(cos_w) : 33'(sin_w);
            end
            ST_M2, ST_M4:
            begin
                ma = 33'(q_reg);
                mb = {2'b00, dt_reg};
            end
            ST_SQ:
            begin
                ma = d_reg[ax_reg];
                mb = d_reg[ax_reg];
            end
            ST_CMP:
            begin
                ma = {2'b00, radius_reg};
                mb = {2'b00, radius_reg};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod = ma * mb;
        a_w  = prod >>> 16;
    end

    // Radius test against radius squared from the multiplier, and the count.
    assign hit_in = !far_reg && (acc_reg <= 67'(prod)) && (hit_reg != CNT_MAX);
    assign hit_w  = hit_reg + COUNT_WIDTH'(hit_in);
    assign res_w  = (COUNT_WIDTH > 16 && hit_w > COUNT_WIDTH'(16'hffff)) ? 16'hffff
                    : 16'(hit_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            radius_reg    <= RADIUS_RST;
            pred_x_reg    <= '0;
            pred_y_reg    <= '0;
            pred_z_reg    <= '0;
            hit_reg       <= '0;
            ovf_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (radius_we)
                radius_reg <= radius_wdata;
            if (m_axis_tvalid && m_axis_tready)
                ovf_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                    if (acc_in && s_axis_tuser == ACT_POSE)
                    begin
                        pred_z_reg <= s_axis_tdata[95:64];
                        hit_reg    <= '0;
                        if (s_axis_tlast)
                        begin
                            out_reg       <= '0;
                            ovf_valid_reg <= 1'b1;
                        end
                    end
                ST_M2: pred_x_reg <= sat32(66'(px_reg) + a_w);
                ST_M4: pred_y_reg <= sat32(66'(py_reg) + a_w);
                ST_CMP:
                begin
                    if (last_reg)
                    begin
                        out_reg       <= res_w;
                        hit_reg       <= '0;
                        ovf_valid_reg <= 1'b1;
                    end
                    else
                        hit_reg <= hit_w;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
                if (acc_in)
                begin
                    last_reg <= s_axis_tlast;
                    px_reg   <= s_axis_tdata[31:0];
                    py_reg   <= s_axis_tdata[63:32];
                    vel_reg  <= s_axis_tdata[159:128];
                    dt_reg   <= s_axis_tdata[190:160];
                    // Heading plus 2^31, as an unsigned value.
                    ang_reg  <= 34'({~s_axis_tdata[127], s_axis_tdata[126:96]});
                    ax_reg   <= 2'd0;
                    acc_reg  <= '0;
                    d_reg[0] <= 33'(abs34(34'(signed'(s_axis_tdata[31:0])) - 34'(pred_x_reg)));
                    d_reg[1] <= 33'(abs34(34'(signed'(s_axis_tdata[63:32])) - 34'(pred_y_reg)));
                    d_reg[2] <= 33'(abs34(34'(signed'(s_axis_tdata[95:64])) - 34'(pred_z_reg)));
                end
            // Quotient estimate, at most one below the true quotient.
            ST_MOD:  q_reg <= 32'(prod[63:50]);
            // Remainder estimate in [0, 4*pi).
            ST_REM:  ang_reg <= ang_reg - signed'(prod[33:0]);
            // Exact remainder, bias removed.
            ST_WRAP:
            begin
                if (ang_reg >= TWO_PI_Q16)
                    ang_reg <= ang_reg - TWO_PI_Q16 - HEAD_BIAS;
                else
                    ang_reg <= ang_reg - HEAD_BIAS;
            end
            // Bring the angle into (-pi, pi].
            ST_NORM:
            begin
                if (ang_reg > PI_Q16)
                    ang_reg <= ang_reg - TWO_PI_Q16;
            end
            ST_M1, ST_M3: q_reg <= sat32(prod >>> 16);
            ST_SQ:
            begin
                acc_reg <= acc_reg + 67'(prod);
                ax_reg  <= ax_reg + 2'd1;
                far_reg <= (d_reg[0] > 33'(radius_reg)) || (d_reg[1] > 33'(radius_reg))
                           || (d_reg[2] > 33'(radius_reg));
            end
            default: ;
        endcase
    end

    ppcc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cstart),
        .angle   (ang_reg > HALF_PI_Q16 ? ang_reg - PI_Q16 :
                  (ang_reg < -HALF_PI_Q16 ? ang_reg + PI_Q16 : ang_reg)),
        .negate  ((ang_reg > HALF_PI_Q16) || (ang_reg < -HALF_PI_Q16)),
        .done    (cdone),
        .cos_q16 (cos_w),
        .sin_q16 (sin_w)
    );

    // No item is taken while the sequencer is working.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    // The counter never wraps.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(hit_reg) == CNT_MAX && st_reg != ST_IDLE) |-> (hit_reg == CNT_MAX || hit_reg == '0))
        else $error("count wrapped");
    // A held result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("result changed");

endmodule : predicted_pose_coverage_count
`default_nettype wire
